>>> src/lrctd_pkg.sv
// Shared types and constants for the LRC frame receiver and tag decoder.
// No dependencies; imported by lrctd_ctrl, lrctd_dp and the top level.
`default_nettype none

package lrctd_pkg;

    localparam int FRAME_CAP = 256;
    localparam int EPC_MAX   = 12;
    localparam int K_W       = $clog2(EPC_MAX + 1);

    localparam logic [7:0] HDR_BYTE = 8'hA0;
    localparam logic [7:0] TAG_CMD  = 8'h89;

    localparam logic [3:0] LAST_STEP = 4'd10;

    localparam logic [1:0] KIND_TAG    = 2'd0;
    localparam logic [1:0] KIND_OTHER  = 2'd1;
    localparam logic [1:0] KIND_CKSUM  = 2'd2;
    localparam logic [1:0] KIND_BADLEN = 2'd3;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_LEN,
        ST_BODY,
        ST_RD,
        ST_CAP,
        ST_DECIDE,
        ST_EPC_RD,
        ST_EPC_CAP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic hdr_load;
        logic len_load;
        logic body_load;
        logic lrc_load;
        logic rd_issue;
        logic rd_capture;
        logic epc_issue;
        logic epc_capture;
        logic out_bad_len;
        logic out_simple;
    } t_dp_cmd;

    typedef struct packed {
        logic is_hdr;
        logic len_bad;
        logic body_last;
        logic lrc_ok;
        logic step_done;
        logic is_tag;
        logic out_last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> src/lrctd_ctrl.sv
// Controller FSM: sequences byte intake, frame-end fetches and result output.
// Depends on lrctd_pkg; drives lrctd_dp through t_dp_cmd.
`default_nettype none

module lrctd_ctrl
    import lrctd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_in_fire;
    logic   w_out_fire;

    assign o_in_ready  = (r_state == ST_HUNT) || (r_state == ST_LEN) || (r_state == ST_BODY);
    assign o_out_valid = (r_state == ST_OUT);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_fire  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_HUNT: begin
                if (w_in_fire && i_stat.is_hdr) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (w_in_fire) begin
                    n_state = i_stat.len_bad ? ST_OUT : ST_BODY;
                end
            end
            ST_BODY: begin
                if (w_in_fire && i_stat.body_last) begin
                    n_state = ST_RD;
                end
            end
            ST_RD:      n_state = ST_CAP;
            ST_CAP:     n_state = i_stat.step_done ? ST_DECIDE : ST_RD;
            ST_DECIDE:  n_state = (i_stat.lrc_ok && i_stat.is_tag) ? ST_EPC_RD : ST_OUT;
            ST_EPC_RD:  n_state = ST_EPC_CAP;
            ST_EPC_CAP: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_fire) begin
                    n_state = i_stat.out_last ? ST_HUNT : ST_EPC_RD;
                end
            end
            default:    n_state = ST_HUNT;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.hdr_load    = (r_state == ST_HUNT) && w_in_fire && i_stat.is_hdr;
        o_cmd.len_load    = (r_state == ST_LEN) && w_in_fire && !i_stat.len_bad;
        o_cmd.out_bad_len = (r_state == ST_LEN) && w_in_fire && i_stat.len_bad;
        o_cmd.body_load   = (r_state == ST_BODY) && w_in_fire && !i_stat.body_last;
        o_cmd.lrc_load    = (r_state == ST_BODY) && w_in_fire && i_stat.body_last;
        o_cmd.rd_issue    = (r_state == ST_RD);
        o_cmd.rd_capture  = (r_state == ST_CAP);
        o_cmd.out_simple  = (r_state == ST_DECIDE) && !(i_stat.lrc_ok && i_stat.is_tag);
        o_cmd.epc_issue   = (r_state == ST_EPC_RD);
        o_cmd.epc_capture = (r_state == ST_EPC_CAP);
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output handshakes open together");

    a_last_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && i_stat.out_last) |=> (r_state == ST_HUNT))
        else $error("final result did not return to header hunt");

    a_lrc_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lrc_load |=> (r_state == ST_RD) && !o_in_ready)
        else $error("checksum byte did not start the fetch sequence");

    a_more_to_epc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && !i_stat.out_last) |=> (r_state == ST_EPC_RD))
        else $error("tag run stopped before its last result");

endmodule

`default_nettype wire

>>> src/lrctd_dp.sv
// Datapath: frame store, length/checksum tracking, field capture, result registers.
// Depends on lrctd_pkg; steered by lrctd_ctrl through t_dp_cmd.
`default_nettype none

module lrctd_dp
    import lrctd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_rx_byte,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    output logic [1:0]       o_frame_kind,
    output logic [7:0]       o_command,
    output logic [7:0]       o_status_code,
    output logic [7:0]       o_antenna,
    output logic [15:0]      o_protocol_control,
    output logic [31:0]      o_signal_raw,
    output logic signed [8:0] o_signal_level,
    output logic [23:0]      o_carrier_freq,
    output logic [3:0]       o_epc_length,
    output logic [7:0]       o_epc_byte,
    output logic             o_last
);

    logic [7:0]     r_mem [256];
    logic [7:0]     r_rdata;

    logic [7:0]     r_len;
    logic [7:0]     r_cnt;
    logic [7:0]     r_sum;
    logic           r_lrc_ok;
    logic [3:0]     r_step;
    logic [K_W-1:0] r_k;

    logic [7:0]     r_cmd;
    logic [7:0]     r_ant;
    logic [15:0]    r_pc;
    logic [31:0]    r_rssi;
    logic [23:0]    r_freq;
    logic [1:0]     r_kind;
    logic [7:0]     r_status;
    logic [7:0]     r_epc_byte;
    logic           r_last;

    logic [7:0]       w_n;
    logic [7:0]       w_step_addr;
    logic [7:0]       w_rd_addr;
    logic             w_tag;
    logic signed [8:0] w_dbm;

    assign w_n         = r_len - 8'd14;
    assign w_step_addr = (r_step < 4'd4) ? (8'd3 + {4'b0000, r_step})
                                         : (r_len - 8'd11 + {4'b0000, r_step});
    assign w_rd_addr   = i_cmd.epc_issue ? (8'd7 + 8'(r_k)) : w_step_addr;

    assign o_stat.is_hdr    = (i_rx_byte == HDR_BYTE);
    assign o_stat.len_bad   = (i_rx_byte < 8'd3) ||
                              ((10'(i_rx_byte) + 10'd2) > 10'(FRAME_CAP));
    assign o_stat.body_last = (9'(r_cnt) + 9'd1) >= 9'(r_len);
    assign o_stat.lrc_ok    = r_lrc_ok;
    assign o_stat.step_done = (r_step == LAST_STEP);
    assign o_stat.is_tag    = (r_cmd == TAG_CMD) && (r_len >= 8'd15) &&
                              (9'(r_len) <= 9'(14 + EPC_MAX));
    assign o_stat.out_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.body_load) begin
            r_mem[r_cnt + 8'd2] <= i_rx_byte;
        end
        if (i_cmd.rd_issue || i_cmd.epc_issue) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_lrc_ok <= 1'b0;
            r_step   <= '0;
            r_k      <= '0;
        end else begin
            if (i_cmd.hdr_load) begin
                r_sum <= HDR_BYTE;
            end
            if (i_cmd.len_load) begin
                r_len <= i_rx_byte;
                r_sum <= r_sum + i_rx_byte;
                r_cnt <= '0;
            end
            if (i_cmd.body_load) begin
                r_cnt <= r_cnt + 8'd1;
                r_sum <= r_sum + i_rx_byte;
            end
            if (i_cmd.lrc_load) begin
                r_lrc_ok <= ((8'd0 - r_sum) == i_rx_byte);
                r_step   <= '0;
                r_k      <= '0;
            end
            if (i_cmd.rd_capture) begin
                r_step <= r_step + 4'd1;
            end
            if (i_cmd.epc_capture) begin
                r_k <= r_k + K_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_capture) begin
            case (r_step) inside
                4'd0:          r_cmd       <= r_rdata;
                4'd1:          r_ant       <= r_rdata;
                4'd2:          r_pc[15:8]  <= r_rdata;
                4'd3:          r_pc[7:0]   <= r_rdata;
                [4'd4:4'd7]:   r_rssi      <= {r_rssi[23:0], r_rdata};
                [4'd8:4'd10]:  r_freq      <= {r_freq[15:0], r_rdata};
                default:       r_cmd       <= r_cmd;
            endcase
        end
        if (i_cmd.epc_capture) begin
            r_kind     <= KIND_TAG;
            r_status   <= '0;
            r_epc_byte <= r_rdata;
            r_last     <= ((8'(r_k) + 8'd1) == w_n);
        end
        if (i_cmd.out_simple) begin
            r_kind   <= r_lrc_ok ? KIND_OTHER : KIND_CKSUM;
            r_status <= (r_lrc_ok && (r_len >= 8'd4)) ? r_ant : 8'd0;
            r_last   <= 1'b1;
        end
        if (i_cmd.out_bad_len) begin
            r_kind   <= KIND_BADLEN;
            r_status <= '0;
            r_last   <= 1'b1;
        end
    end

    // second RSSI byte, halved and negated, less 30
    assign w_dbm = -$signed({2'b00, r_rssi[23:17]}) - 9'sd30;
    assign w_tag = (r_kind == KIND_TAG);

    assign o_frame_kind       = r_kind;
    assign o_command          = (r_kind == KIND_BADLEN) ? 8'd0 : r_cmd;
    assign o_status_code      = r_status;
    assign o_antenna          = w_tag ? r_ant : 8'd0;
    assign o_protocol_control = w_tag ? r_pc : 16'd0;
    assign o_signal_raw       = w_tag ? r_rssi : 32'd0;
    assign o_signal_level     = w_tag ? w_dbm : 9'sd0;
    assign o_carrier_freq     = w_tag ? r_freq : 24'd0;
    assign o_epc_length       = w_tag ? w_n[3:0] : 4'd0;
    assign o_epc_byte         = w_tag ? r_epc_byte : 8'd0;
    assign o_last             = r_last;

endmodule

`default_nettype wire

>>> src/lrc_frame_receiver_tag_decoder.sv
// Top level of the LRC frame receiver and tag-report decoder.
// Depends on lrctd_pkg, lrctd_ctrl and lrctd_dp.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_ready    i_rx_byte
//   out       output     o_out_valid / i_out_ready  o_frame_kind .. o_last (11 fields)
//
// Header, length and body bytes are taken one per cycle; a bad length byte
// offers its result in the next cycle.
// At frame end 11 stored bytes are fetched through the single frame-store read
// port, each by a read state and a capture state; then the frame is classified.
// A non-tag result is then offered at once; each tag result passes through a
// store read, a capture and the output state, which can stall on i_out_ready.
// No bytes are taken while results are pending; i_rst_n is synchronous, active low.
`default_nettype none

module lrc_frame_receiver_tag_decoder
    import lrctd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [7:0]   i_rx_byte,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [1:0]        o_frame_kind,
    output logic [7:0]        o_command,
    output logic [7:0]        o_status_code,
    output logic [7:0]        o_antenna,
    output logic [15:0]       o_protocol_control,
    output logic [31:0]       o_signal_raw,
    output logic signed [8:0] o_signal_level,
    output logic [23:0]       o_carrier_freq,
    output logic [3:0]        o_epc_length,
    output logic [7:0]        o_epc_byte,
    output logic              o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    lrctd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lrctd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rx_byte          (i_rx_byte),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_frame_kind       (o_frame_kind),
        .o_command          (o_command),
        .o_status_code      (o_status_code),
        .o_antenna          (o_antenna),
        .o_protocol_control (o_protocol_control),
        .o_signal_raw       (o_signal_raw),
        .o_signal_level     (o_signal_level),
        .o_carrier_freq     (o_carrier_freq),
        .o_epc_length       (o_epc_length),
        .o_epc_byte         (o_epc_byte),
        .o_last             (o_last)
    );

endmodule

`default_nettype wire
